### hw/rtl/totp_code_generate_verify_defines.svh
// ----------------------------------------------------------------------------
// totp assertion macros
// shared property shapes for the totp block
// ----------------------------------------------------------------------------
`ifndef TOTP_CODE_GENERATE_VERIFY_DEFINES_SVH
`define TOTP_CODE_GENERATE_VERIFY_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TOTP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("totp assertion failed");

// next-cycle implication, checked out of reset
`define TOTP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("totp assertion failed");

`endif

### hw/rtl/totp_pkg.sv
// ----------------------------------------------------------------------------
// totp_pkg
// types, constants and helpers shared by the totp generator and checker
// ----------------------------------------------------------------------------
package totp_pkg;

	localparam int SECRET_BYTES = 20;

	// transfer payloads
	typedef struct packed {
		logic [62:0] unix_seconds;
		logic [29:0] presented_code;
	} totp_in_t;

	typedef struct packed {
		logic [29:0]        current_code;
		logic               code_matches;
		logic signed [3:0]  match_offset;
	} totp_out_t;

	// configuration register indexes
	localparam logic [2:0] REG_KEY_HIGH  = 3'd0;
	localparam logic [2:0] REG_KEY_MID   = 3'd1;
	localparam logic [2:0] REG_KEY_LOW   = 3'd2;
	localparam logic [2:0] REG_STEP      = 3'd3;
	localparam logic [2:0] REG_DIGITS    = 3'd4;
	localparam logic [2:0] REG_TOLERANCE = 3'd5;

	// sha-1 initial chaining value
	localparam logic [159:0] SHA_H0 =
		160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

	// round constants
	localparam logic [31:0] SHA_K0 = 32'h5A827999;
	localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
	localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
	localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

	// padded message lengths in bits
	localparam logic [63:0] INNER_BITS = 64'd576;
	localparam logic [63:0] OUTER_BITS = 64'd672;

	// 10 to the power of a clamped digit count
	function automatic logic [29:0] pow10(input logic [3:0] digits);
		logic [29:0] m;
		unique case (digits)
			4'd1:    m = 30'd10;
			4'd2:    m = 30'd100;
			4'd3:    m = 30'd1000;
			4'd4:    m = 30'd10000;
			4'd5:    m = 30'd100000;
			4'd6:    m = 30'd1000000;
			4'd7:    m = 30'd10000000;
			4'd8:    m = 30'd100000000;
			default: m = 30'd1000000000;
		endcase
		return m;
	endfunction

endpackage

### hw/rtl/totp_sha1.sv
// ----------------------------------------------------------------------------
// totp_sha1
// sha-1 compression, one round per clock, 16-word message schedule shift line
// ----------------------------------------------------------------------------
module totp_sha1 import totp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [511:0] block,
	input  logic [159:0] hin,
	output logic         done,
	output logic [159:0] hout
);

	logic         busy_q, fin_q, done_q;
	logic [6:0]   rnd_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  w_q [16];
	logic [159:0] hin_q, hout_q;
	logic [31:0]  f, k, t, wnew, wx;

	// round function and constant
	always_comb begin
		priority if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = SHA_K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = SHA_K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = SHA_K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = SHA_K3;
		end
		t    = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		wx   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wnew = {wx[30:0], wx[31]};
	end

	// round sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'd79) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// working variables and schedule
	always_ff @(posedge clk) begin
		if (start) begin
			hin_q <= hin;
			a_q <= hin[159:128];
			b_q <= hin[127:96];
			c_q <= hin[95:64];
			d_q <= hin[63:32];
			e_q <= hin[31:0];
			for (int j = 0; j < 16; j++) begin
				w_q[j] <= block[511 - 32*j -: 32];
			end
		end else if (busy_q) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int j = 0; j < 15; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[15] <= wnew;
		end else if (fin_q) begin
			hout_q <= {hin_q[159:128] + a_q, hin_q[127:96] + b_q,
				hin_q[95:64] + c_q, hin_q[63:32] + d_q, hin_q[31:0] + e_q};
		end
	end

	assign done = done_q;
	assign hout = hout_q;

endmodule

### hw/rtl/totp_div.sv
// ----------------------------------------------------------------------------
// totp_div
// restoring divider, one quotient bit per clock, 64-bit dividend
// ----------------------------------------------------------------------------
module totp_div import totp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [29:0] divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic [29:0] remainder
);

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [29:0] rem_q, div_q;
	logic [30:0] trial, diff;
	logic        ge;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, dvd_q[63]};
		diff  = trial - {1'b0, div_q};
		ge    = trial >= {1'b0, div_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[29:0] : trial[29:0];
			dvd_q <= {dvd_q[62:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

### hw/rtl/totp_code_generate_verify.sv
// ----------------------------------------------------------------------------
// totp_code_generate_verify
// time-based one-time code generation and checking with hmac-sha1
// ----------------------------------------------------------------------------
// One item at a time. The time is divided by the step length in the
// divider, then each computed window runs four sha-1 compressions on the
// single one-round-per-clock core and a modulo on the same divider. The
// current window is always computed; the others are tried from the most
// negative offset up and the search stops at the first match. The input is
// stalled until the result has been transferred.
`include "totp_code_generate_verify_defines.svh"

module totp_code_generate_verify import totp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  totp_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output totp_out_t   out_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_TDIV, S_H1, S_H2, S_H3, S_H4, S_MOD, S_WIN, S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [63:0] key_high_q, key_mid_q;
	logic [31:0] key_low_q;
	logic [11:0] step_q;
	logic [3:0]  digits_q;
	logic [2:0]  tol_q;

	// item and working registers
	logic [62:0]       now_q;
	logic [29:0]       pres_q, cur_q;
	logic [63:0]       q_q, ctr_q;
	logic [159:0]      chain_q, ihash_q, mac_q;
	logic signed [3:0] off_q;
	logic              cur_phase_q, sha_start_q, div_start_q, out_valid_q;
	totp_out_t         out_q;

	// derived values
	logic [11:0]       step_eff;
	logic [3:0]        digits_eff;
	logic [2:0]        tol_eff;
	logic [29:0]       modulus;
	logic [159:0]      key, pad_i, pad_o, mac_sh;
	logic [511:0]      blk;
	logic [159:0]      hin;
	logic [31:0]       bin;
	logic [63:0]       ctr_next, div_dvd;
	logic [29:0]       div_dsr;
	logic [3:0]        off_mag;
	logic              skip, past_end;
	logic signed [3:0] tol_s;

	logic         sha_done, div_done;
	logic [159:0] sha_hout;
	logic [63:0]  div_quot;
	logic [29:0]  div_rem;

	// clamped settings
	always_comb begin
		step_eff   = (step_q == '0) ? 12'd1 : step_q;
		digits_eff = (digits_q == '0) ? 4'd1 : ((digits_q > 4'd9) ? 4'd9 : digits_q);
		tol_eff    = (tol_q > 3'd4) ? 3'd4 : tol_q;
		tol_s      = signed'({1'b0, tol_eff});
		modulus    = pow10(digits_eff);
	end

	// hmac message blocks
	always_comb begin
		key   = {key_high_q, key_mid_q, key_low_q};
		pad_i = key ^ {SECRET_BYTES{8'h36}};
		pad_o = key ^ {SECRET_BYTES{8'h5C}};
		unique case (state_q)
			S_H1:    blk = {pad_i, {(64 - SECRET_BYTES){8'h36}}};
			S_H2:    blk = {ctr_q, 8'h80, 376'b0, INNER_BITS};
			S_H3:    blk = {pad_o, {(64 - SECRET_BYTES){8'h5C}}};
			default: blk = {ihash_q, 8'h80, 280'b0, OUTER_BITS};
		endcase
		hin = (state_q == S_H1 || state_q == S_H3) ? SHA_H0 : chain_q;
	end

	// dynamic truncation and divider operands
	always_comb begin
		mac_sh  = mac_q << {mac_q[3:0], 3'b000};
		bin     = {1'b0, mac_sh[158:128]};
		div_dvd = (state_q == S_TDIV) ? {1'b0, now_q} : 64'(bin);
		div_dsr = (state_q == S_TDIV) ? 30'(step_eff) : modulus;
	end

	// window selection
	always_comb begin
		off_mag  = 4'(-off_q);
		ctr_next = q_q + {{60{off_q[3]}}, off_q};
		skip     = (off_q < 0) && (q_q < 64'(off_mag));
		past_end = off_q > tol_s;
	end

	totp_sha1 u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sha_start_q),
		.block  (blk),
		.hin    (hin),
		.done   (sha_done),
		.hout   (sha_hout)
	);

	totp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_mid_q  <= '0;
			key_low_q  <= '0;
			step_q     <= 12'd30;
			digits_q   <= 4'd6;
			tol_q      <= 3'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KEY_HIGH:  key_high_q <= cfg_data;
				REG_KEY_MID:   key_mid_q  <= cfg_data;
				REG_KEY_LOW:   key_low_q  <= cfg_data[31:0];
				REG_STEP:      step_q     <= cfg_data[11:0];
				REG_DIGITS:    digits_q   <= cfg_data[3:0];
				REG_TOLERANCE: tol_q      <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sha_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			cur_phase_q <= 1'b0;
		end else begin
			sha_start_q <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						now_q       <= in_data.unix_seconds;
						pres_q      <= in_data.presented_code;
						div_start_q <= 1'b1;
						state_q     <= S_TDIV;
					end
				end
				S_TDIV: begin
					if (div_done) begin
						q_q         <= div_quot;
						ctr_q       <= div_quot;
						cur_phase_q <= 1'b1;
						sha_start_q <= 1'b1;
						state_q     <= S_H1;
					end
				end
				S_H1: begin
					if (sha_done) begin
						chain_q     <= sha_hout;
						sha_start_q <= 1'b1;
						state_q     <= S_H2;
					end
				end
				S_H2: begin
					if (sha_done) begin
						ihash_q     <= sha_hout;
						sha_start_q <= 1'b1;
						state_q     <= S_H3;
					end
				end
				S_H3: begin
					if (sha_done) begin
						chain_q     <= sha_hout;
						sha_start_q <= 1'b1;
						state_q     <= S_H4;
					end
				end
				S_H4: begin
					if (sha_done) begin
						mac_q       <= sha_hout;
						div_start_q <= 1'b1;
						state_q     <= S_MOD;
					end
				end
				S_MOD: begin
					if (div_done) begin
						if (cur_phase_q) begin
							cur_q       <= div_rem;
							cur_phase_q <= 1'b0;
							off_q       <= -tol_s;
							state_q     <= S_WIN;
						end else if (div_rem == pres_q) begin
							out_q       <= '{cur_q, 1'b1, off_q};
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							off_q   <= off_q + 4'sd1;
							state_q <= S_WIN;
						end
					end
				end
				S_WIN: begin
					if (past_end) begin
						out_q       <= '{cur_q, 1'b0, 4'sd0};
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else if (off_q == 4'sd0) begin
						if (cur_q == pres_q) begin
							out_q       <= '{cur_q, 1'b1, 4'sd0};
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							off_q <= off_q + 4'sd1;
						end
					end else if (skip) begin
						off_q <= off_q + 4'sd1;
					end else begin
						ctr_q       <= ctr_next;
						sha_start_q <= 1'b1;
						state_q     <= S_H1;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the hash core only finishes while a hash step is waiting on it
	`TOTP_ASSERT_IMP(a_sha_done_in_hash, sha_done,
		state_q == S_H1 || state_q == S_H2 || state_q == S_H3 || state_q == S_H4)
	// the divider only finishes while the sequencer waits on it
	`TOTP_ASSERT_IMP(a_div_done_in_div, div_done, state_q == S_TDIV || state_q == S_MOD)
	// a miss reports offset zero
	`TOTP_ASSERT_IMP(a_miss_offset_zero, out_valid_q && !out_q.code_matches,
		out_q.match_offset == 4'sd0)
	// a started hash step leaves no divider running
	`TOTP_ASSERT_NXT(a_sha_start_exclusive, sha_start_q, !div_done)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// totp code generator and checker testbench
// drives time and code transfers through several register settings, predicts
// the hmac-sha1 one-time code and window search, and checks every result
// ----------------------------------------------------------------------------
module tb;
	import totp_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 3000;

	// expected codes and window search
	class totp_scoreboard;
		bit [63:0] key_hi;
		bit [63:0] key_md;
		bit [31:0] key_lo;
		bit [11:0] step_r;
		bit [3:0]  digits_r;
		bit [2:0]  tol_r;
		totp_out_t expected_q[$];
		int errors;

		function new();
			key_hi = 0;
			key_md = 0;
			key_lo = 0;
			step_r = 12'd30;
			digits_r = 4'd6;
			tol_r = 3'd1;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] d);
			case (idx)
				REG_KEY_HIGH:  key_hi = d;
				REG_KEY_MID:   key_md = d;
				REG_KEY_LOW:   key_lo = d[31:0];
				REG_STEP:      step_r = d[11:0];
				REG_DIGITS:    digits_r = d[3:0];
				REG_TOLERANCE: tol_r = d[2:0];
				default: ;
			endcase
		endfunction

		function bit [63:0] step_len();
			return (step_r == 0) ? 64'd1 : 64'(step_r);
		endfunction

		function int tol_eff();
			return (tol_r > 4) ? 4 : int'(tol_r);
		endfunction

		function bit [31:0] modulus();
			int n;
			bit [31:0] m;
			n = (digits_r < 1) ? 1 : ((digits_r > 9) ? 9 : int'(digits_r));
			m = 1;
			for (int i = 0; i < n; i++)
				m = m * 10;
			return m;
		endfunction

		// one sha-1 block
		function bit [159:0] compress(bit [159:0] h, bit [511:0] blk);
			bit [31:0] w[80];
			bit [31:0] a, b, c, d, e, f, k, t;
			for (int i = 0; i < 16; i++)
				w[i] = blk[511 - 32 * i -: 32];
			for (int i = 16; i < 80; i++) begin
				t = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
				w[i] = {t[30:0], t[31]};
			end
			{a, b, c, d, e} = h;
			for (int i = 0; i < 80; i++) begin
				if (i < 20) begin
					f = (b & c) | (~b & d);
					k = SHA_K0;
				end else if (i < 40) begin
					f = b ^ c ^ d;
					k = SHA_K1;
				end else if (i < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = SHA_K2;
				end else begin
					f = b ^ c ^ d;
					k = SHA_K3;
				end
				t = {a[26:0], a[31:27]} + f + e + k + w[i];
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = t;
			end
			return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d,
				h[31:0] + e};
		endfunction

		// hmac over the counter, truncated and reduced
		function bit [29:0] code_for(bit [63:0] ctr);
			bit [511:0] kb;
			bit [159:0] inner, mac;
			bit [3:0] off;
			bit [31:0] word;
			kb = {key_hi, key_md, key_lo, 352'b0};
			inner = compress(SHA_H0, kb ^ {64{8'h36}});
			inner = compress(inner, {ctr, 8'h80, 376'b0, INNER_BITS});
			mac = compress(SHA_H0, kb ^ {64{8'h5C}});
			mac = compress(mac, {inner, 8'h80, 280'b0, OUTER_BITS});
			off = mac[3:0];
			word = mac[159 - 8 * off -: 32];
			return 30'({1'b0, word[30:0]} % modulus());
		endfunction

		// time of a window, 0 when it falls before the epoch
		function bit window_time(bit [62:0] now, int off, output bit [63:0] t);
			bit [63:0] delta;
			delta = 64'(off < 0 ? -off : off) * step_len();
			t = 64'(now);
			if (off < 0) begin
				if (64'(now) < delta)
					return 0;
				t = 64'(now) - delta;
			end else begin
				t = 64'(now) + delta;
			end
			return 1;
		endfunction

		// code of a window, or of the current period when it is skipped
		function bit [29:0] window_code(bit [62:0] now, int off);
			bit [63:0] t;
			if (!window_time(now, off, t))
				t = 64'(now);
			return code_for(t / step_len());
		endfunction

		function totp_out_t predict(totp_in_t x);
			totp_out_t r;
			bit [63:0] t;
			bit [29:0] c;
			int tol;
			tol = tol_eff();
			r.current_code = code_for(64'(x.unix_seconds) / step_len());
			r.code_matches = 0;
			r.match_offset = 0;
			for (int i = -tol; i <= tol; i++) begin
				if (r.code_matches)
					break;
				if (!window_time(x.unix_seconds, i, t))
					continue;
				c = (i == 0) ? r.current_code : code_for(t / step_len());
				if (c == x.presented_code) begin
					r.code_matches = 1;
					r.match_offset = 4'(i);
				end
			end
			return r;
		endfunction

		function void note_input(totp_in_t x);
			expected_q.insert(expected_q.size(), predict(x));
		endfunction

		function void check_result(totp_out_t y);
			totp_out_t e;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: %h", y);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (y.current_code !== e.current_code) begin
				$error("current_code expected %0d actual %0d", e.current_code, y.current_code);
				errors++;
			end
			if (y.code_matches !== e.code_matches) begin
				$error("code_matches expected %0d actual %0d", e.code_matches, y.code_matches);
				errors++;
			end
			if (y.match_offset !== e.match_offset) begin
				$error("match_offset expected %0d actual %0d", e.match_offset, y.match_offset);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	totp_in_t    in_data;
	logic        out_valid;
	logic        out_stall;
	totp_out_t   out_data;

	totp_scoreboard sb;
	bit quiet;
	bit hold_req;
	int cycles;

	totp_code_generate_verify dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// clock
	initial clk = 0;
	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic bit idle_now();
		return quiet ? 0 : ($urandom_range(0, 99) < 36);
	endfunction

	// receiver stalls, with one long hold-off on request
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end
			out_stall = idle_now();
		end
	end

	// result monitor
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL totp_code_generate_verify");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] d);
		@(negedge clk);
		cfg_write = 1;
		cfg_index = idx;
		cfg_data = d;
		@(posedge clk);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_write = 0;
	endtask

	task automatic send_item(bit [62:0] now, bit [29:0] code);
		totp_in_t it;
		it.unix_seconds = now;
		it.presented_code = code;
		@(negedge clk);
		while (idle_now()) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		in_data = it;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(it);
	endtask

	// wait until every expected result has come
	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic bit [62:0] pick_time();
		bit [63:0] st;
		st = sb.step_len();
		case ($urandom_range(0, 3))
			0: return 63'({$urandom, $urandom});
			1: return 63'($urandom_range(0, 32'(5 * st)));
			2: return 63'h7FFF_FFFF_FFFF_FFFF - 63'($urandom_range(0, 32'(5 * st)));
			default: return 63'($urandom);
		endcase
	endfunction

	// mostly codes that belong to some window, the rest noise
	task automatic send_random();
		bit [62:0] now;
		int r, tol;
		now = pick_time();
		r = $urandom_range(0, 99);
		tol = sb.tol_eff();
		if (r < 60)
			send_item(now, sb.window_code(now, $urandom_range(0, 2 * tol) - tol));
		else if (r < 80)
			send_item(now, 30'($urandom % sb.modulus()));
		else
			send_item(now, 30'($urandom));
	endtask

	task automatic run_random(int n);
		repeat (n) send_random();
		drain();
	endtask

	task automatic set_all(logic [63:0] kh, logic [63:0] km, logic [31:0] kl,
			logic [11:0] st, logic [3:0] dg, logic [2:0] tl);
		write_reg(REG_KEY_HIGH, kh);
		write_reg(REG_KEY_MID, km);
		write_reg(REG_KEY_LOW, 64'(kl));
		write_reg(REG_STEP, 64'(st));
		write_reg(REG_DIGITS, 64'(dg));
		write_reg(REG_TOLERANCE, 64'(tl));
	endtask

	initial begin
		sb = new();
		quiet = 0;
		hold_req = 0;
		cycles = 0;
		arst_n = 0;
		cfg_write = 0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = 0;
		in_valid = 0;
		in_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed at reset settings: epoch, top of time range, window edges
		send_item(0, sb.window_code(0, 0));
		send_item(0, 0);
		send_item(63'h7FFF_FFFF_FFFF_FFFF, sb.window_code(63'h7FFF_FFFF_FFFF_FFFF, 1));
		send_item(63'h7FFF_FFFF_FFFF_FFFF, 30'h3FFF_FFFF);
		send_item(45, sb.window_code(45, -1));
		send_item(29, sb.window_code(29, 1));
		send_item(1000, 30'd999999);
		send_item(1000, 30'd1000000);
		drain();

		// directed at edges: zero step, digit clamps, tolerance clamp, stray index
		set_all(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
			12'd0, 4'd0, 3'd7);
		write_reg(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(3'd7, 64'h1234_5678_9ABC_DEF0);
		send_item(2, sb.window_code(2, -2));
		send_item(3, sb.window_code(3, -4));
		send_item(100, sb.window_code(100, 4));
		send_item(100, 30'd10);
		drain();
		write_reg(REG_DIGITS, 64'd15);
		write_reg(REG_TOLERANCE, 64'd4);
		send_item(500, sb.window_code(500, -3));
		send_item(500, 30'h3FFF_FFFF);
		drain();
		write_reg(REG_STEP, 64'd3600);
		write_reg(REG_DIGITS, 64'd1);
		write_reg(REG_TOLERANCE, 64'd0);
		send_item(7199, sb.window_code(7199, 0));
		send_item(7199, 30'd9);
		send_item(7199, 30'd10);
		drain();

		// random phases
		set_all({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 12'd1, 4'd9, 3'd0);
		run_random(120);
		set_all(0, 0, 0, 12'd3600, 4'd1, 3'd2);
		run_random(60);
		quiet = 1;
		set_all({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 12'd0, 4'd0, 3'd0);
		run_random(80);
		quiet = 0;
		set_all({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
			12'($urandom_range(1, 4095)), 4'd12, 3'd7);
		run_random(25);
		set_all({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 12'd30, 4'd8, 3'd1);
		hold_req = 1;
		run_random(120);
		for (int p = 0; p < 5; p++) begin
			set_all({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
				12'($urandom_range(1, 4095)), 4'($urandom_range(1, 9)),
				3'($urandom_range(0, 3)));
			run_random(30);
		end

		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS totp_code_generate_verify");
		else
			$display("FAIL totp_code_generate_verify");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/totp_pkg.sv
hw/rtl/totp_sha1.sv
hw/rtl/totp_div.sv
hw/rtl/totp_code_generate_verify.sv
tb/sv/tb.sv
